// File: design/cle_pkg.sv
//------------------------------------------------------------------------------
// cle_pkg: shared definitions for the cooked line editor
// Character codes, register indexes, the controller state type and the
// configuration bundle handed from the top level to the controller.
//------------------------------------------------------------------------------
`default_nettype none

package cle_pkg;

	// Default line length; the store holds one entry per byte of the line.
	localparam int LINE_LEN_DEF = 64;

	// Byte and configuration port widths.
	localparam int BYTE_W     = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 1;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_RAW_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CR_TO_NL = 1'b1;

	// Character codes.
	localparam logic [BYTE_W-1:0] CH_BS   = 8'h08;
	localparam logic [BYTE_W-1:0] CH_NL   = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_EOF  = 8'h04;
	localparam logic [BYTE_W-1:0] CH_KILL = 8'h15;

	// Controller states: taking bytes, or reading a finished line out.
	typedef enum logic {
		ST_IDLE,
		ST_DRAIN
	} state_t;

	// Configuration seen by the controller.
	typedef struct packed {
		logic raw_mode;
		logic cr_to_nl;
		logic clear_line;
	} cfg_t;

endpackage

`default_nettype wire

// File: design/cle_ram.sv
//------------------------------------------------------------------------------
// cle_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and holds its
// value while no read is issued.
//------------------------------------------------------------------------------
`default_nettype none

module cle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: design/cle_ctrl.sv
//------------------------------------------------------------------------------
// cle_ctrl: line editing controller
// Decodes each request, keeps the fill count, writes bytes into the line
// store and reads a finished line back out through the output register.
//------------------------------------------------------------------------------
`default_nettype none

module cle_ctrl
	import cle_pkg::*;
#(
	parameter int LINE_LEN = LINE_LEN_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire cfg_t                         cfg,
	input  wire logic                         in_valid,
	output      logic                         in_stall,
	input  wire logic [BYTE_W-1:0]            data_in,
	output      logic                         out_valid,
	input  wire logic                         out_stall,
	output      logic [BYTE_W-1:0]            data_out,
	output      logic                         last,
	output      logic                         empty_record,
	output      logic                         ram_we,
	output      logic [$clog2(LINE_LEN)-1:0]  ram_waddr,
	output      logic [BYTE_W-1:0]            ram_wdata,
	output      logic                         ram_re,
	output      logic [$clog2(LINE_LEN)-1:0]  ram_raddr,
	input  wire logic [BYTE_W-1:0]            ram_rdata
);

	localparam int AW = $clog2(LINE_LEN);
	localparam int CW = $clog2(LINE_LEN + 1);

	state_t state_q, state_d;

	logic [CW-1:0]     fill_q;
	logic [CW-1:0]     rd_ptr_q;
	logic              pend_s1;
	logic              last_s1;
	logic              out_valid_q;
	logic [BYTE_W-1:0] data_out_q;
	logic              last_q;
	logic              empty_q;

	logic [BYTE_W-1:0] ch;
	logic              in_acc;
	logic              out_free;
	logic              is_bs;
	logic              is_kill;
	logic              is_end;
	logic [CW-1:0]     app_cnt;
	logic [CW-1:0]     line_cnt;
	logic              line_done;
	logic              line_empty;
	logic              load_in;
	logic              load_rd;
	logic              issue;

	// Carriage return mapping and handshake terms.
	assign ch       = (cfg.cr_to_nl && data_in == CH_CR) ? CH_NL : data_in;
	assign out_free = !out_valid_q || !out_stall;
	assign in_acc   = in_valid && !in_stall;

	// Decode of the byte against the current fill count.
	always_comb begin
		is_bs      = (ch == CH_BS);
		is_kill    = (ch == CH_KILL);
		is_end     = (ch == CH_NL) || (ch == CH_EOF);
		app_cnt    = fill_q + 1'b1;
		line_done  = !is_bs && !is_kill && (is_end || app_cnt == CW'(LINE_LEN));
		line_cnt   = (ch == CH_EOF) ? fill_q : app_cnt;
		line_empty = (line_cnt == '0);
	end

	// A raw byte or an empty record goes to the output register directly.
	assign load_in = in_acc && (cfg.raw_mode || (line_done && line_empty));
	// A byte read from the store moves on once the output register has room.
	assign load_rd = pend_s1 && out_free;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && !cfg.raw_mode && line_done && !line_empty) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (load_rd && last_s1) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State outputs: input stall and store accesses.
	always_comb begin
		in_stall = 1'b1;
		issue    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = !out_free;
			end
			ST_DRAIN: begin
				issue = (rd_ptr_q != fill_q) && (!pend_s1 || load_rd);
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	assign ram_we    = in_acc && !cfg.raw_mode && !is_bs && !is_kill;
	assign ram_waddr = fill_q[AW-1:0];
	assign ram_wdata = ch;
	assign ram_re    = issue;
	assign ram_raddr = rd_ptr_q[AW-1:0];

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Fill count: edited by each cooked byte, cleared when a line is delivered or the raw mode register is written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cfg.clear_line) begin
			fill_q <= '0;
		end else if (state_q == ST_DRAIN && load_rd && last_s1) begin
			fill_q <= '0;
		end else if (in_acc && !cfg.raw_mode) begin
			if (is_bs) begin
				if (fill_q != '0) begin
					fill_q <= fill_q - 1'b1;
				end
			end else if (is_kill) begin
				fill_q <= '0;
			end else if (line_done) begin
				fill_q <= line_cnt;
			end else begin
				fill_q <= app_cnt;
			end
		end
	end

	// Read pointer and the byte in flight from the store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			pend_s1  <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			if (in_acc) begin
				rd_ptr_q <= '0;
			end else if (issue) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (issue) begin
				pend_s1 <= 1'b1;
				last_s1 <= (rd_ptr_q + 1'b1 == fill_q);
			end else if (load_rd) begin
				pend_s1 <= 1'b0;
			end
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_in || load_rd) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load_rd) begin
			data_out_q <= ram_rdata;
			last_q     <= last_s1;
			empty_q    <= 1'b0;
		end else if (load_in) begin
			data_out_q <= cfg.raw_mode ? ch : '0;
			last_q     <= 1'b1;
			empty_q    <= !cfg.raw_mode;
		end
	end

	assign out_valid    = out_valid_q;
	assign data_out     = data_out_q;
	assign last         = last_q;
	assign empty_record = empty_q;

endmodule

`default_nettype wire

// File: design/cooked_line_editor_top.sv
//------------------------------------------------------------------------------
// cooked_line_editor_top: console input line discipline
// Holds the configuration registers and joins the controller to the line
// store.
//
//   channel   | direction | handshake        | payload
//   ----------+-----------+------------------+----------------------------------
//   input     | in        | in_valid/in_stall | data_in
//   output    | out       | out_valid/out_stall | data_out, last, empty_record
//   config    | in        | cfg_wr_en        | cfg_index, cfg_data
//
// A finished line is read from the store one byte at a time through the
// store's registered read port; no request is taken meanwhile.
// Reset clears the fill count and the output valid and sets the registers to
// cooked mode with carriage return mapping on; the store needs no clearing pass.
// A stall on the output holds the read-out and, when the output register
// is full, the input.
//------------------------------------------------------------------------------
`default_nettype none

module cooked_line_editor_top
	import cle_pkg::*;
#(
	parameter int LINE_LEN = LINE_LEN_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output      logic                  in_stall,
	input  wire logic [BYTE_W-1:0]     data_in,
	output      logic                  out_valid,
	input  wire logic                  out_stall,
	output      logic [BYTE_W-1:0]     data_out,
	output      logic                  last,
	output      logic                  empty_record
);

	localparam int AW = $clog2(LINE_LEN);

	logic raw_mode_q;
	logic cr_to_nl_q;
	cfg_t cfg;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [BYTE_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [BYTE_W-1:0] ram_rdata;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_mode_q <= 1'b0;
			cr_to_nl_q <= 1'b1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_RAW_MODE: raw_mode_q <= cfg_data[0];
				CFG_CR_TO_NL: cr_to_nl_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// A write to the raw mode register also drops the partial line.
	always_comb begin
		cfg.raw_mode   = raw_mode_q;
		cfg.cr_to_nl   = cr_to_nl_q;
		cfg.clear_line = cfg_wr_en && (cfg_index == CFG_RAW_MODE);
	end

	cle_ctrl #(
		.LINE_LEN (LINE_LEN)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_in      (data_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.data_out     (data_out),
		.last         (last),
		.empty_record (empty_record),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata)
	);

	cle_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (LINE_LEN)
	) u_line_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

`default_nettype wire

// File: design/cle_checker.sv
//------------------------------------------------------------------------------
// cle_checker: port-level checks for the cooked line editor
// Watches the top-level ports and flags record framing errors.
//------------------------------------------------------------------------------
`default_nettype none

module cle_checker
	import cle_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_stall,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic [BYTE_W-1:0] data_out,
	input wire logic              last,
	input wire logic              empty_record
);

	// An empty record is always a single, final request.
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_record |-> last)
		else $error("empty record without last");

	// An empty record carries a zero byte.
	a_empty_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_record |-> data_out == '0)
		else $error("empty record with non-zero data");

	// While a record is part way out, no new input is taken.
	a_no_input_mid_record: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> in_stall)
		else $error("input taken in the middle of a record");

	// A stalled output request holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(data_out) && $stable(last)
			&& $stable(empty_record))
		else $error("stalled output request changed");

endmodule

bind cooked_line_editor_top cle_checker u_cle_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.data_out     (data_out),
	.last         (last),
	.empty_record (empty_record)
);

`default_nettype wire
